### rtl/edge_partition_from_vertex_parts_defines.svh
// ----------------------------------------------------------------------------
// edge_partition_from_vertex_parts_defines.svh
// Assertion macros for the edge partition block
// ----------------------------------------------------------------------------
`ifndef EDGE_PARTITION_FROM_VERTEX_PARTS_DEFINES_SVH
`define EDGE_PARTITION_FROM_VERTEX_PARTS_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication, sampled on clk, off during reset
`define EPVP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define EPVP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define EPVP_ASSERT_NOW(label, ante, cons, msg)

`define EPVP_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### rtl/epvp_pkg.sv
// ----------------------------------------------------------------------------
// epvp_pkg
// Shared sizes, beat types, command and state codes for the edge partitioner
// ----------------------------------------------------------------------------
package epvp_pkg;

  // sizing of the graph
  localparam int MAX_VERTICES = 64;
  localparam int NUM_PARTS    = 4;

  localparam int VERT_W    = $clog2(MAX_VERTICES);
  localparam int PART_W    = $clog2(NUM_PARTS);
  localparam int ROW_AW    = PART_W + VERT_W;
  localparam int ROW_DEPTH = 1 << ROW_AW;
  localparam int CNT_W     = $clog2(MAX_VERTICES + 1);
  localparam int REPL_W    = $clog2(NUM_PARTS * MAX_VERTICES + 1);

  // popcount split into chunks
  localparam int CHUNK_W     = 8;
  localparam int NUM_CHUNKS  = (MAX_VERTICES + CHUNK_W - 1) / CHUNK_W;
  localparam int PAD_W       = NUM_CHUNKS * CHUNK_W;
  localparam int CHUNK_CNT_W = $clog2(CHUNK_W + 1);

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // port field widths
  localparam int F_VERT_W = 6;
  localparam int F_PART_W = 2;
  localparam int F_REPL_W = 9;

  // request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EDGE = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [F_VERT_W-1:0] first_vertex;
    logic [F_VERT_W-1:0] second_vertex;
    logic [F_PART_W-1:0] vertex_part;
  } item_t;

  typedef struct packed {
    logic                edge_valid;
    logic [F_PART_W-1:0] edge_part;
    logic [F_REPL_W-1:0] replica_count;
  } result_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_EDGE,
    CMD_SKIP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [VERT_W-1:0] u;
    logic [VERT_W-1:0] v;
    logic [PART_W-1:0] part;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PV,
    ST_RU,
    ST_RV,
    ST_CNT1,
    ST_CNT2,
    ST_SEL,
    ST_WA,
    ST_RB,
    ST_WB,
    ST_DONE
  } back_state_t;

  typedef struct packed {
    logic [REPL_W-1:0] replica;
    logic              row_write;
  } back_status_t;

  // ones in one chunk of a row
  function automatic logic [CHUNK_CNT_W-1:0] chunk_count(input logic [CHUNK_W-1:0] x);
    logic [CHUNK_CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < CHUNK_W; i++) begin
      n = n + CHUNK_CNT_W'(x[i]);
    end
    return n;
  endfunction

  // one-hot row mask for a neighbor vertex
  function automatic logic [MAX_VERTICES-1:0] row_bit(input logic [VERT_W-1:0] vtx);
    logic [MAX_VERTICES-1:0] m;
    m      = '0;
    m[vtx] = 1'b1;
    return m;
  endfunction

endpackage

### rtl/epvp_ram.sv
// ----------------------------------------------------------------------------
// epvp_ram
// Generic simple dual-port RAM, one write port, one registered read port
// ----------------------------------------------------------------------------
module epvp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/epvp_front.sv
// ----------------------------------------------------------------------------
// epvp_front
// Accepts input beats, range-checks and decodes them into commands, and
// holds them in a short queue for the back end
// ----------------------------------------------------------------------------
module epvp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  epvp_pkg::item_t      item,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output epvp_pkg::cmd_t       cmd
);

  epvp_pkg::cmd_t              new_cmd;
  logic                        u_ok;
  logic                        v_ok;
  epvp_pkg::cmd_t              q_mem [epvp_pkg::QUEUE_DEPTH];
  logic [epvp_pkg::QPTR_W-1:0] wr_ptr;
  logic [epvp_pkg::QPTR_W-1:0] rd_ptr;
  logic [epvp_pkg::QCNT_W-1:0] count;
  logic                        push;
  logic                        pop;

  // decode and range check
  always_comb begin
    u_ok = 32'(item.first_vertex) < 32'(epvp_pkg::MAX_VERTICES);
    v_ok = 32'(item.second_vertex) < 32'(epvp_pkg::MAX_VERTICES);
    new_cmd.u = epvp_pkg::VERT_W'(item.first_vertex);
    new_cmd.v = epvp_pkg::VERT_W'(item.second_vertex);
    // part beyond the last one saturates
    if (32'(item.vertex_part) >= 32'(epvp_pkg::NUM_PARTS)) begin
      new_cmd.part = epvp_pkg::PART_W'(epvp_pkg::NUM_PARTS - 1);
    end else begin
      new_cmd.part = epvp_pkg::PART_W'(item.vertex_part);
    end
    case (item.req_type)
      epvp_pkg::REQ_LOAD: begin
        new_cmd.kind = u_ok ? epvp_pkg::CMD_LOAD : epvp_pkg::CMD_SKIP;
      end
      epvp_pkg::REQ_EDGE: begin
        new_cmd.kind = (u_ok && v_ok) ? epvp_pkg::CMD_EDGE : epvp_pkg::CMD_SKIP;
      end
      default: begin
        new_cmd.kind = epvp_pkg::CMD_SKIP;
      end
    endcase
  end

  // queue handshakes
  assign item_ready = count != epvp_pkg::QCNT_W'(epvp_pkg::QUEUE_DEPTH);
  assign cmd_valid  = count != '0;
  assign cmd        = q_mem[rd_ptr];
  assign push       = item_valid && item_ready;
  assign pop        = cmd_valid && cmd_ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= new_cmd;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == epvp_pkg::QPTR_W'(epvp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == epvp_pkg::QPTR_W'(epvp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/epvp_back.sv
// ----------------------------------------------------------------------------
// epvp_back
// Executes commands: part table writes for loads, and for edges the part
// lookups, own-part degree compare and the two neighbor row updates
// ----------------------------------------------------------------------------
module epvp_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  epvp_pkg::cmd_t         cmd,
  output logic                   result_valid,
  input  logic                   result_ready,
  output epvp_pkg::result_t      result,
  output epvp_pkg::back_status_t status
);

  epvp_pkg::back_state_t              state;
  epvp_pkg::back_state_t              state_next;
  epvp_pkg::cmd_t                     cur;
  logic [epvp_pkg::PART_W-1:0]        pu;
  logic [epvp_pkg::PART_W-1:0]        pv;
  logic [epvp_pkg::PART_W-1:0]        chosen;
  logic [epvp_pkg::PART_W-1:0]        chosen_c;
  logic [epvp_pkg::MAX_VERTICES-1:0]  row_u;
  logic [epvp_pkg::MAX_VERTICES-1:0]  row_v;
  logic [epvp_pkg::PAD_W-1:0]         pad_u;
  logic [epvp_pkg::PAD_W-1:0]         pad_v;
  logic [epvp_pkg::CHUNK_CNT_W-1:0]   cu_chunk [epvp_pkg::NUM_CHUNKS];
  logic [epvp_pkg::CHUNK_CNT_W-1:0]   cv_chunk [epvp_pkg::NUM_CHUNKS];
  logic [epvp_pkg::CNT_W-1:0]         sum_u;
  logic [epvp_pkg::CNT_W-1:0]         sum_v;
  logic [epvp_pkg::CNT_W-1:0]         cnt_u;
  logic [epvp_pkg::CNT_W-1:0]         cnt_v;
  logic [epvp_pkg::ROW_DEPTH-1:0]     nonempty;
  logic [epvp_pkg::REPL_W-1:0]        replica;
  logic                               out_valid;
  logic                               out_free;
  epvp_pkg::result_t                  out_data;

  // part table port signals
  logic                               part_we;
  logic [epvp_pkg::VERT_W-1:0]        part_waddr;
  logic [epvp_pkg::PART_W-1:0]        part_wdata;
  logic                               part_re;
  logic [epvp_pkg::VERT_W-1:0]        part_raddr;
  logic [epvp_pkg::PART_W-1:0]        part_rdata;

  // neighbor row memory port signals
  logic                               row_we;
  logic [epvp_pkg::MAX_VERTICES-1:0]  row_wdata;
  logic                               row_re;
  logic [epvp_pkg::ROW_AW-1:0]        row_raddr;
  logic [epvp_pkg::ROW_AW-1:0]        row_raddr_q;
  logic [epvp_pkg::MAX_VERTICES-1:0]  row_rdata;
  logic [epvp_pkg::MAX_VERTICES-1:0]  row_masked;

  epvp_ram #(
    .WIDTH (epvp_pkg::PART_W),
    .DEPTH (epvp_pkg::MAX_VERTICES)
  ) u_part_ram (
    .clk     (clk),
    .wr_en   (part_we),
    .wr_addr (part_waddr),
    .wr_data (part_wdata),
    .rd_en   (part_re),
    .rd_addr (part_raddr),
    .rd_data (part_rdata)
  );

  epvp_ram #(
    .WIDTH (epvp_pkg::MAX_VERTICES),
    .DEPTH (epvp_pkg::ROW_DEPTH)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (row_we),
    .wr_addr (row_raddr_q),
    .wr_data (row_wdata),
    .rd_en   (row_re),
    .rd_addr (row_raddr),
    .rd_data (row_rdata)
  );

  // a row never written reads as empty
  assign row_masked = nonempty[row_raddr_q] ? row_rdata : '0;
  assign out_free   = !out_valid || result_ready;

  // part choice: shared part, else the end with more own-part neighbors, first end on a tie
  assign chosen_c = (pu == pv) ? pu : ((cnt_u >= cnt_v) ? pu : pv);

  // padded rows for the chunked popcount
  assign pad_u = epvp_pkg::PAD_W'(row_u);
  assign pad_v = epvp_pkg::PAD_W'(row_v);

  // chunk count sums
  always_comb begin
    sum_u = '0;
    sum_v = '0;
    for (int c = 0; c < epvp_pkg::NUM_CHUNKS; c++) begin
      sum_u = sum_u + epvp_pkg::CNT_W'(cu_chunk[c]);
      sum_v = sum_v + epvp_pkg::CNT_W'(cv_chunk[c]);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      epvp_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          state_next = (cmd.kind == epvp_pkg::CMD_EDGE) ? epvp_pkg::ST_PV : epvp_pkg::ST_DONE;
        end
      end
      epvp_pkg::ST_PV:   state_next = epvp_pkg::ST_RU;
      epvp_pkg::ST_RU:   state_next = epvp_pkg::ST_RV;
      epvp_pkg::ST_RV:   state_next = epvp_pkg::ST_CNT1;
      epvp_pkg::ST_CNT1: state_next = epvp_pkg::ST_CNT2;
      epvp_pkg::ST_CNT2: state_next = epvp_pkg::ST_SEL;
      epvp_pkg::ST_SEL:  state_next = epvp_pkg::ST_WA;
      epvp_pkg::ST_WA:   state_next = epvp_pkg::ST_RB;
      epvp_pkg::ST_RB:   state_next = epvp_pkg::ST_WB;
      epvp_pkg::ST_WB:   state_next = epvp_pkg::ST_DONE;
      epvp_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = epvp_pkg::ST_IDLE;
        end
      end
      default: state_next = epvp_pkg::ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    cmd_ready  = 1'b0;
    part_we    = 1'b0;
    part_waddr = cmd.u;
    part_wdata = cmd.part;
    part_re    = 1'b0;
    part_raddr = cmd.u;
    row_we     = 1'b0;
    row_re     = 1'b0;
    row_raddr  = {part_rdata, cur.u};
    row_wdata  = row_masked | epvp_pkg::row_bit(cur.u);
    case (state)
      epvp_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          part_we = cmd.kind == epvp_pkg::CMD_LOAD;
          part_re = cmd.kind == epvp_pkg::CMD_EDGE;
        end
      end
      epvp_pkg::ST_PV: begin
        part_re    = 1'b1;
        part_raddr = cur.v;
        row_re     = 1'b1;
        row_raddr  = {part_rdata, cur.u};
      end
      epvp_pkg::ST_RU: begin
        row_re    = 1'b1;
        row_raddr = {part_rdata, cur.v};
      end
      epvp_pkg::ST_SEL: begin
        row_re    = 1'b1;
        row_raddr = {chosen_c, cur.u};
      end
      epvp_pkg::ST_WA: begin
        row_we    = 1'b1;
        row_wdata = row_masked | epvp_pkg::row_bit(cur.v);
      end
      epvp_pkg::ST_RB: begin
        row_re    = 1'b1;
        row_raddr = {chosen, cur.v};
      end
      epvp_pkg::ST_WB: begin
        row_we    = 1'b1;
        row_wdata = row_masked | epvp_pkg::row_bit(cur.u);
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

  // control state, row occupancy and replica count
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= epvp_pkg::ST_IDLE;
      nonempty  <= '0;
      replica   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // first bit in a row adds one replica
      if (row_we) begin
        nonempty[row_raddr_q] <= 1'b1;
        if (!nonempty[row_raddr_q]) begin
          replica <= replica + 1'b1;
        end
      end
      if (state == epvp_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (result_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == epvp_pkg::ST_IDLE && cmd_valid) begin
      cur <= cmd;
    end
    if (row_re) begin
      row_raddr_q <= row_raddr;
    end
    case (state)
      epvp_pkg::ST_PV: begin
        pu <= part_rdata;
      end
      epvp_pkg::ST_RU: begin
        pv    <= part_rdata;
        row_u <= row_masked;
      end
      epvp_pkg::ST_RV: begin
        row_v <= row_masked;
      end
      epvp_pkg::ST_CNT1: begin
        for (int c = 0; c < epvp_pkg::NUM_CHUNKS; c++) begin
          cu_chunk[c] <= epvp_pkg::chunk_count(pad_u[c*epvp_pkg::CHUNK_W +: epvp_pkg::CHUNK_W]);
          cv_chunk[c] <= epvp_pkg::chunk_count(pad_v[c*epvp_pkg::CHUNK_W +: epvp_pkg::CHUNK_W]);
        end
      end
      epvp_pkg::ST_CNT2: begin
        cnt_u <= sum_u;
        cnt_v <= sum_v;
      end
      epvp_pkg::ST_SEL: begin
        chosen <= chosen_c;
      end
      epvp_pkg::ST_DONE: begin
        if (out_free) begin
          out_data.edge_valid    <= cur.kind == epvp_pkg::CMD_EDGE;
          out_data.edge_part     <= (cur.kind == epvp_pkg::CMD_EDGE) ?
                                    epvp_pkg::F_PART_W'(chosen) : '0;
          out_data.replica_count <= epvp_pkg::F_REPL_W'(replica);
        end
      end
      default: begin
        cnt_u <= cnt_u;
      end
    endcase
  end

  assign result_valid     = out_valid;
  assign result           = out_data;
  assign status.replica   = replica;
  assign status.row_write = row_we;

endmodule

### rtl/edge_partition_from_vertex_parts.sv
// ----------------------------------------------------------------------------
// edge_partition_from_vertex_parts
// Edge partition derived from a vertex partition. Load beats set a vertex's
// part; edge beats are assigned to the shared part of their ends, or else to
// the part of the end with more distinct own-part neighbors (first end wins
// ties), and each returns the part and the running count of nonempty
// part-vertex neighbor rows. Every input beat gives exactly one result beat.
// A load or out-of-range beat goes from idle straight to the done state of
// the sequencer; an edge steps through all states: two part-table reads,
// four row reads and two row writes use single read and write ports one
// after another, and the own-part neighbor counts come from a chunked
// popcount of the rows, chunk counts first, then their sum. A two-entry
// command queue in front lets input beats arrive while one executes, and
// an output register holds a finished result while the next is worked on.
// Neighbor rows are tracked by one occupancy flop per row, cleared by reset,
// so the block is ready right after reset with no clearing pass.
// ----------------------------------------------------------------------------
`include "edge_partition_from_vertex_parts_defines.svh"

module edge_partition_from_vertex_parts (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  epvp_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_ready,
  output epvp_pkg::result_t   result
);

  logic                   cmd_valid;
  logic                   cmd_ready;
  epvp_pkg::cmd_t         cmd;
  epvp_pkg::back_status_t status;

  // decode and queue
  epvp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  // execution and result register
  epvp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .status       (status)
  );

  // replica count only grows, by at most one per cycle
  `EPVP_ASSERT_NEXT(a_replica_step, 1'b1, (status.replica == $past(status.replica)) || (status.replica == $past(status.replica) + 1'b1), "replica count stepped wrongly")

  // replica count changes only after a row write
  `EPVP_ASSERT_NOW(a_replica_cause, status.replica != $past(status.replica), $past(status.row_write), "replica count changed without a row write")

  // an edge result implies at least one nonempty row
  `EPVP_ASSERT_NOW(a_edge_has_row, result_valid && result.edge_valid, result.replica_count != '0, "edge result with zero replicas")

  // non-edge results carry part zero
  `EPVP_ASSERT_NOW(a_nonedge_part, result_valid && !result.edge_valid, result.edge_part == '0, "non-edge result with nonzero part")

endmodule

### test/edge_partition_from_vertex_parts_tb.sv
// ----------------------------------------------------------------------------
// edge_partition_from_vertex_parts_tb
// Self-checking bench for the edge partitioner. A directed table covers the
// corner cases: loads after reset, shared and split parts, degree ties,
// repeated edges, self loops and reloads. Next come loads of all vertices
// and 1820 random beats, mostly edges with reloads. Every accepted beat runs
// through a local model of the part table, the neighbor bitmaps, the own-part
// degrees and the replica total. The expected result of each beat is queued
// and compared field by field with the result beats, in order.
// ----------------------------------------------------------------------------
module edge_partition_from_vertex_parts_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import epvp_pkg::*;

  localparam int RANDOM_ITEMS = 1820;

  typedef struct {
    item_t   beat;
    bit      typed;
    result_t want;
  } plan_row_t;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_ready;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  // model of the block state
  logic [F_PART_W-1:0]     part_tab [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] nbr_rows [NUM_PARTS*MAX_VERTICES];
  int                      own_deg  [MAX_VERTICES];
  logic [F_REPL_W-1:0]     replicas;

  result_t   expected_results [$];
  plan_row_t plan_table [$];
  int        mismatches = 0;
  bit        steady     = 1'b0;

  edge_partition_from_vertex_parts DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop if the run hangs
  initial begin
    #5_000_000;
    $display("edge_partition_from_vertex_parts_tb: FAIL");
    $finish;
  end

  // set neighbor bit col in row; true when the bit is new
  function automatic bit mark_neighbor(input int row, input int col);
    if (nbr_rows[row][col]) begin
      return 1'b0;
    end
    if (nbr_rows[row] == '0) begin
      replicas = replicas + 1'b1;
    end
    nbr_rows[row][col] = 1'b1;
    return 1'b1;
  endfunction

  // apply one input beat to the model and return its result
  function automatic result_t place_beat(input item_t beat);
    result_t          res;
    int               u;
    int               v;
    logic [F_PART_W-1:0] pu;
    logic [F_PART_W-1:0] pv;
    logic [F_PART_W-1:0] chosen;
    u   = int'(beat.first_vertex);
    v   = int'(beat.second_vertex);
    res = '0;
    if (beat.req_type == REQ_LOAD) begin
      part_tab[u] = beat.vertex_part;
      own_deg[u]  = $countones(nbr_rows[int'(beat.vertex_part) * MAX_VERTICES + u]);
    end else begin
      pu = part_tab[u];
      pv = part_tab[v];
      if (pu == pv) begin
        chosen = pu;
      end else begin
        chosen = (own_deg[u] >= own_deg[v]) ? pu : pv;
      end
      if (mark_neighbor(int'(chosen) * MAX_VERTICES + u, v) && chosen == pu) begin
        own_deg[u]++;
      end
      if (mark_neighbor(int'(chosen) * MAX_VERTICES + v, u) && chosen == pv) begin
        own_deg[v]++;
      end
      res.edge_valid = 1'b1;
      res.edge_part  = chosen;
    end
    res.replica_count = replicas;
    return res;
  endfunction

  function automatic plan_row_t plan_row(input logic kind, input int u, input int v,
                                         input int p, input bit typed, input int part,
                                         input int repl);
    plan_row_t r;
    r.beat.req_type         = kind;
    r.beat.first_vertex     = F_VERT_W'(u);
    r.beat.second_vertex    = F_VERT_W'(v);
    r.beat.vertex_part      = F_PART_W'(p);
    r.typed                 = typed;
    r.want.edge_valid       = (kind == REQ_EDGE);
    r.want.edge_part        = F_PART_W'(part);
    r.want.replica_count    = F_REPL_W'(repl);
    return r;
  endfunction

  // vertex choice biased to a small hot set so rows and repeats build up
  function automatic logic [F_VERT_W-1:0] pick_vertex();
    if ($urandom_range(99) < 50) begin
      return F_VERT_W'($urandom_range(7));
    end
    return F_VERT_W'($urandom_range(MAX_VERTICES - 1));
  endfunction

  // present one beat, wait for the handshake, queue its expected result
  task automatic drive_beat(input item_t beat, input bit typed, input result_t want);
    result_t predicted;
    @(negedge clk);
    while (!steady && $urandom_range(99) < 36) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= beat;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    predicted = place_beat(beat);
    expected_results.push_back(typed ? want : predicted);
  endtask

  // hold off the sender until every result is back
  task automatic drain_results();
    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // result side backpressure
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= steady || ($urandom_range(99) >= 36);
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: %p", result);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (result.edge_valid !== want.edge_valid) begin
          $error("edge_valid expected %0d actual %0d", want.edge_valid, result.edge_valid);
          mismatches++;
        end
        if (result.edge_part !== want.edge_part) begin
          $error("edge_part expected %0d actual %0d", want.edge_part, result.edge_part);
          mismatches++;
        end
        if (result.replica_count !== want.replica_count) begin
          $error("replica_count expected %0d actual %0d", want.replica_count,
                 result.replica_count);
          mismatches++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int                  order [MAX_VERTICES];
    int                  j;
    int                  tmp;
    item_t               beat;
    logic [F_VERT_W-1:0] u;

    for (int i = 0; i < MAX_VERTICES; i++) begin
      part_tab[i] = '0;
      own_deg[i]  = 0;
    end
    for (int i = 0; i < NUM_PARTS * MAX_VERTICES; i++) begin
      nbr_rows[i] = '0;
    end
    replicas = '0;

    // reset
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    plan_table = '{
      // loads right after reset report no replicas
      plan_row(REQ_LOAD, 0, 63, 0, 1'b1, 0, 0),
      plan_row(REQ_LOAD, 63, 0, 3, 1'b1, 0, 0),
      plan_row(REQ_LOAD, 1, 42, 0, 1'b1, 0, 0),
      plan_row(REQ_LOAD, 2, 21, 1, 1'b1, 0, 0),
      plan_row(REQ_LOAD, 3, 63, 2, 1'b1, 0, 0),
      // both ends in part 0, two new rows
      plan_row(REQ_EDGE, 0, 1, 3, 1'b1, 0, 2),
      // same edge again, ends swapped
      plan_row(REQ_EDGE, 1, 0, 2, 1'b0, 0, 0),
      // self loop on the top vertex
      plan_row(REQ_EDGE, 63, 63, 1, 1'b0, 0, 0),
      // split parts, equal degrees: first end wins
      plan_row(REQ_EDGE, 2, 3, 0, 1'b0, 0, 0),
      // split parts, second end has the larger degree
      plan_row(REQ_EDGE, 3, 0, 3, 1'b0, 0, 0),
      // reload into a part where its row is already populated
      plan_row(REQ_LOAD, 3, 0, 0, 1'b0, 0, 0),
      plan_row(REQ_EDGE, 3, 2, 1, 1'b0, 0, 0),
      // reload into a part with an empty row
      plan_row(REQ_LOAD, 0, 63, 2, 1'b0, 0, 0),
      plan_row(REQ_EDGE, 0, 63, 3, 1'b0, 0, 0),
      plan_row(REQ_EDGE, 63, 0, 0, 1'b0, 0, 0),
      plan_row(REQ_LOAD, 63, 63, 0, 1'b0, 0, 0),
      plan_row(REQ_EDGE, 63, 63, 3, 1'b0, 0, 0),
      plan_row(REQ_EDGE, 0, 0, 0, 1'b0, 0, 0),
      plan_row(REQ_EDGE, 1, 63, 2, 1'b0, 0, 0)
    };
    foreach (plan_table[k]) begin
      drive_beat(plan_table[k].beat, plan_table[k].typed, plan_table[k].want);
    end
    drain_results();

    // load every vertex in shuffled order before random edges
    for (int i = 0; i < MAX_VERTICES; i++) begin
      order[i] = i;
    end
    for (int i = MAX_VERTICES - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < MAX_VERTICES; i++) begin
      beat.req_type      = REQ_LOAD;
      beat.first_vertex  = F_VERT_W'(order[i]);
      beat.second_vertex = F_VERT_W'($urandom);
      beat.vertex_part   = F_PART_W'($urandom);
      drive_beat(beat, 1'b0, '0);
    end

    // random edges with reloads mixed in
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 900 && n < 1200);
      if (n % 400 == 399) begin
        drain_results();
      end
      if ($urandom_range(99) < 20) begin
        beat.req_type      = REQ_LOAD;
        beat.first_vertex  = pick_vertex();
        beat.second_vertex = F_VERT_W'($urandom);
        beat.vertex_part   = F_PART_W'($urandom);
      end else begin
        u                  = pick_vertex();
        beat.req_type      = REQ_EDGE;
        beat.first_vertex  = u;
        beat.second_vertex = ($urandom_range(19) == 0) ? u : pick_vertex();
        beat.vertex_part   = F_PART_W'($urandom);
      end
      drive_beat(beat, 1'b0, '0);
    end
    steady = 1'b0;

    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("edge_partition_from_vertex_parts_tb: PASS");
    end else begin
      $display("edge_partition_from_vertex_parts_tb: FAIL");
    end
    $finish;
  end

endmodule
